FILE: hdl/socd_pkg.sv
// Shared constants, types and stick mapping for the SOCD button-to-stick mapper.
// No dependencies.
package socd_pkg;

    localparam int unsigned DIR_W  = 4;
    localparam int unsigned FACE_W = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BTN_W  = 8;

    // Bit positions in a direction field
    localparam int unsigned DIR_LEFT  = 0;
    localparam int unsigned DIR_RIGHT = 1;
    localparam int unsigned DIR_UP    = 2;
    localparam int unsigned DIR_DOWN  = 3;

    // Bit positions in the face key field
    localparam int unsigned FK_A     = 0;
    localparam int unsigned FK_B     = 1;
    localparam int unsigned FK_X     = 2;
    localparam int unsigned FK_Y1    = 3;
    localparam int unsigned FK_Y2    = 4;
    localparam int unsigned FK_Z     = 5;
    localparam int unsigned FK_L     = 6;
    localparam int unsigned FK_R1    = 7;
    localparam int unsigned FK_R2    = 8;
    localparam int unsigned FK_START = 9;

    // 128 + 80*v + 0.5 rounded down, for v = 0, 1, 0.7
    localparam logic [BYTE_W-1:0] COORD_NEUTRAL = 8'd128;
    localparam logic [BYTE_W-1:0] COORD_FULL    = 8'd208;
    localparam logic [BYTE_W-1:0] COORD_DIAG    = 8'd184;

    typedef struct packed {
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
    } t_xy;

    function automatic t_xy map_stick(input logic horiz, input logic neg_x,
                                      input logic vert, input logic neg_y);
        t_xy r;
        r.x = COORD_NEUTRAL;
        r.y = COORD_NEUTRAL;
        if (horiz && vert) begin
            r.x = COORD_DIAG;
            r.y = COORD_DIAG;
        end else if (horiz) begin
            r.x = COORD_FULL;
        end else if (vert) begin
            r.y = COORD_FULL;
        end
        if (horiz && neg_x) begin
            r.x = BYTE_W'(~r.x + 1'b1);
        end
        if (vert && neg_y) begin
            r.y = BYTE_W'(~r.y + 1'b1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/socd_button_to_stick_mapper.sv
// SOCD button-to-stick mapper: input register, single logic stage, result register.
// Depends on socd_pkg.
// Data path: an accepted item passes from the input register through the logic stage into the result register.
// Throughput: one item per cycle while the output is not stalled; the block state update sits in the one logic stage.
// Reset (synchronous, i_rst_n low): clears both valid flags, held and blocked bits.
// Result payload registers are not reset and are meaningful only while o_valid is high.
module socd_button_to_stick_mapper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [socd_pkg::DIR_W-1:0]    i_direction_keys,
    input  logic [socd_pkg::DIR_W-1:0]    i_cstick_keys,
    input  logic [socd_pkg::FACE_W-1:0]   i_face_keys,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [socd_pkg::BYTE_W-1:0]   o_stick_x,
    output logic [socd_pkg::BYTE_W-1:0]   o_stick_y,
    output logic [socd_pkg::BYTE_W-1:0]   o_cstick_x,
    output logic [socd_pkg::BYTE_W-1:0]   o_cstick_y,
    output logic [socd_pkg::BTN_W-1:0]    o_report_buttons
);

    logic                          r_in_valid;
    logic [socd_pkg::DIR_W-1:0]    r_dir;
    logic [socd_pkg::DIR_W-1:0]    r_cst;
    logic [socd_pkg::FACE_W-1:0]   r_face;

    logic                          r_out_valid;
    socd_pkg::t_xy                 r_main;
    socd_pkg::t_xy                 r_cxy;
    logic [socd_pkg::BTN_W-1:0]    r_btn;

    logic [socd_pkg::DIR_W-1:0]    r_held;
    logic [socd_pkg::DIR_W-1:0]    r_blk;

    logic                          out_free;
    logic                          adv;
    logic                          in_take;
    logic                          both_lr;
    logic                          both_ud;
    logic [socd_pkg::DIR_W-1:0]    new_blk;
    logic [socd_pkg::DIR_W-1:0]    n_blk;
    logic [socd_pkg::DIR_W-1:0]    eff;
    logic                          c_hor;
    logic                          c_ver;
    socd_pkg::t_xy                 n_main;
    socd_pkg::t_xy                 n_cxy;
    logic [socd_pkg::BTN_W-1:0]    n_btn;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_comb begin
        both_lr = r_dir[socd_pkg::DIR_LEFT] && r_dir[socd_pkg::DIR_RIGHT];
        both_ud = r_dir[socd_pkg::DIR_UP] && r_dir[socd_pkg::DIR_DOWN];
        new_blk = '0;
        new_blk[socd_pkg::DIR_LEFT]  = both_lr && r_held[socd_pkg::DIR_LEFT]
                                       && !r_held[socd_pkg::DIR_RIGHT];
        new_blk[socd_pkg::DIR_RIGHT] = both_lr && r_held[socd_pkg::DIR_RIGHT]
                                       && !r_held[socd_pkg::DIR_LEFT];
        new_blk[socd_pkg::DIR_UP]    = both_ud && r_held[socd_pkg::DIR_UP]
                                       && !r_held[socd_pkg::DIR_DOWN];
        new_blk[socd_pkg::DIR_DOWN]  = both_ud && r_held[socd_pkg::DIR_DOWN]
                                       && !r_held[socd_pkg::DIR_UP];
        n_blk = (r_blk | new_blk) & r_dir;
        eff   = r_dir & ~n_blk;

        n_main = socd_pkg::map_stick(
            eff[socd_pkg::DIR_LEFT] || eff[socd_pkg::DIR_RIGHT],
            !eff[socd_pkg::DIR_RIGHT],
            eff[socd_pkg::DIR_UP] || eff[socd_pkg::DIR_DOWN],
            !eff[socd_pkg::DIR_UP]);

        c_hor = r_cst[socd_pkg::DIR_LEFT] ^ r_cst[socd_pkg::DIR_RIGHT];
        c_ver = r_cst[socd_pkg::DIR_UP] ^ r_cst[socd_pkg::DIR_DOWN];
        n_cxy = socd_pkg::map_stick(c_hor, r_cst[socd_pkg::DIR_LEFT],
                                    c_ver, r_cst[socd_pkg::DIR_DOWN]);

        n_btn = {r_face[socd_pkg::FK_START],
                 r_face[socd_pkg::FK_R1] | r_face[socd_pkg::FK_R2],
                 r_face[socd_pkg::FK_L],
                 r_face[socd_pkg::FK_Z],
                 r_face[socd_pkg::FK_Y1] | r_face[socd_pkg::FK_Y2],
                 r_face[socd_pkg::FK_X],
                 r_face[socd_pkg::FK_B],
                 r_face[socd_pkg::FK_A]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_blk       <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (adv) begin
                r_held <= r_dir;
                r_blk  <= n_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dir  <= i_direction_keys;
            r_cst  <= i_cstick_keys;
            r_face <= i_face_keys;
        end
        if (adv) begin
            r_main <= n_main;
            r_cxy  <= n_cxy;
            r_btn  <= n_btn;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_stick_x        = r_main.x;
    assign o_stick_y        = r_main.y;
    assign o_cstick_x       = r_cxy.x;
    assign o_cstick_y       = r_cxy.y;
    assign o_report_buttons = r_btn;

`ifndef SYNTHESIS
    a_blk_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blk & ~r_held) == '0)
        else $error("blocked direction not held");

    a_blk_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_blk[socd_pkg::DIR_LEFT] && r_blk[socd_pkg::DIR_RIGHT])
        && !(r_blk[socd_pkg::DIR_UP] && r_blk[socd_pkg::DIR_DOWN]))
        else $error("both directions of a pair blocked");

    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_stick_x == 8'd184 || o_stick_x == 8'd72))
        |-> (o_stick_y == 8'd184 || o_stick_y == 8'd72))
        else $error("diagonal x without diagonal y");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked item");
`endif

endmodule

FILE: bench/tb_socd_button_to_stick_mapper.sv
`timescale 1ns / 100ps
// Self-checking bench for socd_button_to_stick_mapper: directed SOCD sequences, then random
// key snapshots under random idling and stalls, checked against an in-bench report predictor.
// Depends on socd_pkg and the RTL of socd_button_to_stick_mapper.
module tb_socd_button_to_stick_mapper;

    localparam logic [socd_pkg::DIR_W-1:0] K_L = socd_pkg::DIR_W'(1) << socd_pkg::DIR_LEFT;
    localparam logic [socd_pkg::DIR_W-1:0] K_R = socd_pkg::DIR_W'(1) << socd_pkg::DIR_RIGHT;
    localparam logic [socd_pkg::DIR_W-1:0] K_U = socd_pkg::DIR_W'(1) << socd_pkg::DIR_UP;
    localparam logic [socd_pkg::DIR_W-1:0] K_D = socd_pkg::DIR_W'(1) << socd_pkg::DIR_DOWN;
    localparam int unsigned IDLE_PCT = 18;
    localparam int unsigned N_RANDOM = 650;

    typedef struct packed {
        logic [socd_pkg::BYTE_W-1:0] stick_x;
        logic [socd_pkg::BYTE_W-1:0] stick_y;
        logic [socd_pkg::BYTE_W-1:0] cstick_x;
        logic [socd_pkg::BYTE_W-1:0] cstick_y;
        logic [socd_pkg::BTN_W-1:0]  buttons;
    } t_stick_report;

    class stick_report_board;
        logic [socd_pkg::DIR_W-1:0] held_dirs;
        logic [socd_pkg::DIR_W-1:0] blocked_dirs;
        t_stick_report              expected_reports[$];
        int                         errors;
        int                         checked;

        function new();
            held_dirs    = '0;
            blocked_dirs = '0;
            errors       = 0;
            checked      = 0;
        endfunction

        function logic [socd_pkg::DIR_W-1:0] lock_pair(logic [socd_pkg::DIR_W-1:0] dirs,
                                                       int unsigned a, int unsigned b);
            logic [socd_pkg::DIR_W-1:0] r;
            r = '0;
            if (dirs[a] && dirs[b]) begin
                if (held_dirs[a] && !held_dirs[b]) r[a] = 1'b1;
                if (held_dirs[b] && !held_dirs[a]) r[b] = 1'b1;
            end
            return r;
        endfunction

        function logic [socd_pkg::BYTE_W-1:0] axis_byte(logic active, logic neg, logic diag);
            logic [socd_pkg::BYTE_W-1:0] mag;
            mag = diag ? socd_pkg::COORD_DIAG : socd_pkg::COORD_FULL;
            if (!active) return socd_pkg::COORD_NEUTRAL;
            return neg ? socd_pkg::BYTE_W'(9'd256 - mag) : mag;
        endfunction

        function void note_snapshot(logic [socd_pkg::DIR_W-1:0] dirs,
                                    logic [socd_pkg::DIR_W-1:0] cdirs,
                                    logic [socd_pkg::FACE_W-1:0] keys);
            logic [socd_pkg::DIR_W-1:0] live;
            logic                       horiz, vert, chor, cver;
            t_stick_report              rpt;
            blocked_dirs = blocked_dirs
                           | lock_pair(dirs, socd_pkg::DIR_LEFT, socd_pkg::DIR_RIGHT)
                           | lock_pair(dirs, socd_pkg::DIR_UP, socd_pkg::DIR_DOWN);
            blocked_dirs = blocked_dirs & dirs;
            held_dirs    = dirs;
            live         = dirs & ~blocked_dirs;
            horiz = live[socd_pkg::DIR_LEFT] | live[socd_pkg::DIR_RIGHT];
            vert  = live[socd_pkg::DIR_UP] | live[socd_pkg::DIR_DOWN];
            rpt.stick_x = axis_byte(horiz, !live[socd_pkg::DIR_RIGHT], horiz && vert);
            rpt.stick_y = axis_byte(vert, !live[socd_pkg::DIR_UP], horiz && vert);
            chor = cdirs[socd_pkg::DIR_LEFT] ^ cdirs[socd_pkg::DIR_RIGHT];
            cver = cdirs[socd_pkg::DIR_UP] ^ cdirs[socd_pkg::DIR_DOWN];
            rpt.cstick_x = axis_byte(chor, cdirs[socd_pkg::DIR_LEFT], chor && cver);
            rpt.cstick_y = axis_byte(cver, cdirs[socd_pkg::DIR_DOWN], chor && cver);
            rpt.buttons = {keys[socd_pkg::FK_START],
                           keys[socd_pkg::FK_R1] | keys[socd_pkg::FK_R2],
                           keys[socd_pkg::FK_L], keys[socd_pkg::FK_Z],
                           keys[socd_pkg::FK_Y1] | keys[socd_pkg::FK_Y2],
                           keys[socd_pkg::FK_X], keys[socd_pkg::FK_B], keys[socd_pkg::FK_A]};
            expected_reports.push_back(rpt);
        endfunction

        function void compare_field(string name, logic [socd_pkg::BYTE_W-1:0] want,
                                    logic [socd_pkg::BYTE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_stick_report got);
            t_stick_report want;
            if (expected_reports.size() == 0) begin
                $error("stick report with nothing expected");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            compare_field("stick_x", want.stick_x, got.stick_x);
            compare_field("stick_y", want.stick_y, got.stick_y);
            compare_field("cstick_x", want.cstick_x, got.cstick_x);
            compare_field("cstick_y", want.cstick_y, got.cstick_y);
            compare_field("report_buttons", want.buttons, got.buttons);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [socd_pkg::DIR_W-1:0]    i_direction_keys;
    logic [socd_pkg::DIR_W-1:0]    i_cstick_keys;
    logic [socd_pkg::FACE_W-1:0]   i_face_keys;
    logic                          o_valid;
    logic                          i_stall;
    logic [socd_pkg::BYTE_W-1:0]   o_stick_x;
    logic [socd_pkg::BYTE_W-1:0]   o_stick_y;
    logic [socd_pkg::BYTE_W-1:0]   o_cstick_x;
    logic [socd_pkg::BYTE_W-1:0]   o_cstick_y;
    logic [socd_pkg::BTN_W-1:0]    o_report_buttons;

    stick_report_board board;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int                sent;

    socd_button_to_stick_mapper u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_direction_keys (i_direction_keys),
        .i_cstick_keys    (i_cstick_keys),
        .i_face_keys      (i_face_keys),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_stick_x        (o_stick_x),
        .o_stick_y        (o_stick_y),
        .o_cstick_x       (o_cstick_x),
        .o_cstick_y       (o_cstick_y),
        .o_report_buttons (o_report_buttons)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_report({o_stick_x, o_stick_y, o_cstick_x, o_cstick_y,
                                o_report_buttons});
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_snapshot(logic [socd_pkg::DIR_W-1:0] dirs,
                                 logic [socd_pkg::DIR_W-1:0] cdirs,
                                 logic [socd_pkg::FACE_W-1:0] keys);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_direction_keys <= dirs;
        i_cstick_keys    <= cdirs;
        i_face_keys      <= keys;
        do @(posedge i_clk); while (o_stall);
        board.note_snapshot(dirs, cdirs, keys);
        sent++;
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        while (board.pending() != 0 && n < 2000) begin
            @(posedge i_clk);
            n++;
        end
        if (board.pending() != 0) begin
            $error("%0d stick reports never arrived", board.pending());
            board.errors++;
        end
    endtask

    initial begin
        logic [socd_pkg::DIR_W-1:0]  dir_seq[23];
        logic [socd_pkg::DIR_W-1:0]  dirs;
        logic [socd_pkg::FACE_W-1:0] keys;
        int unsigned                 r;
        int unsigned                 sel;
        dir_seq = '{'0, K_L, K_R, K_U, K_D, '0, K_L, K_L | K_R, K_L | K_R, K_R, K_L | K_R,
                    K_L, K_L | K_R, '0, K_L | K_R | K_U | K_D, K_L | K_R | K_U | K_D,
                    K_L | K_U, K_R | K_D, K_U, K_U | K_D, K_D, K_U | K_D, '0};
        board          = new();
        sent           = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_direction_keys <= '0;
        i_cstick_keys    <= '0;
        i_face_keys      <= '0;
        i_stall          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 23; i++) begin
            if (i == 0) keys = '0;
            else if (i == 1) keys = '1;
            else keys = socd_pkg::FACE_W'(1) << ((i - 2) % socd_pkg::FACE_W);
            send_snapshot(dir_seq[i], socd_pkg::DIR_W'(i % 16), keys);
        end
        i_valid <= 1'b0;
        wait_drain();

        send_idle_pct  = IDLE_PCT;
        recv_stall_pct = IDLE_PCT;
        dirs = '0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 250) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (i == 400) begin
                send_idle_pct  = IDLE_PCT;
                recv_stall_pct = IDLE_PCT;
            end
            r = $urandom_range(99);
            if (r < 70) begin
                sel = $urandom_range(socd_pkg::DIR_W - 1);
                dirs[sel] = ~dirs[sel];
            end else if (r >= 80) begin
                dirs = socd_pkg::DIR_W'($urandom);
            end
            send_snapshot(dirs, socd_pkg::DIR_W'($urandom), socd_pkg::FACE_W'($urandom));
        end
        i_valid <= 1'b0;
        wait_drain();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d key snapshots (directed SOCD cases, then random press/release runs)",
                 sent);
        $display("Checked %0d stick reports, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
